### src/sspg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspg_pkg
// Types and constants shared by the stepper step-pulse generator files.
// ----------------------------------------------------------------------------
package sspg_pkg;

    localparam int KIND_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CTRL_W      = 15;   // full-scale speed and deadbands
    localparam int FREQ_W      = 16;   // step frequencies
    localparam int MAG_W       = 15;   // clamped speed magnitude

    // Shared arithmetic unit widths.
    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = 35;    // largest product is 1e6 * 32767
    localparam int DIVIDEND_W = 35;
    localparam int DIVISOR_W  = 31;
    localparam int QUO_W      = 20;    // every quotient stays at or below 1e6
    localparam int CNT_W      = $clog2(QUO_W + 1);

    localparam logic [MUL_A_W-1:0] US_PER_S = 20'd1000000;

    localparam logic [CTRL_W-1:0] RST_MAX_CONTROL = 15'd4000;
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ    = 16'd8000;
    localparam logic [CTRL_W-1:0] RST_DB_ENTER    = 15'd128;
    localparam logic [CTRL_W-1:0] RST_DB_EXIT     = 15'd400;
    localparam logic [FREQ_W-1:0] RST_MIN_FREQ    = 16'd600;

    typedef enum logic [KIND_W-1:0] {
        KIND_SPEED   = 3'd0,
        KIND_TICK    = 3'd1,
        KIND_ENABLE  = 3'd2,
        KIND_DISABLE = 3'd3,
        KIND_ESTOP   = 3'd4
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_CONTROL = 3'd0,
        CFG_MAX_FREQ    = 3'd1,
        CFG_DB_ENTER    = 3'd2,
        CFG_DB_EXIT     = 3'd3,
        CFG_MIN_FREQ    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL_NUM,
        SEQ_MUL_MIN,
        SEQ_MUL_SCALE,
        SEQ_DIV_START,
        SEQ_DIV
    } seq_state_t;

    typedef enum logic [1:0] {
        ARITH_NOP,
        ARITH_MUL,
        ARITH_DIV_START,
        ARITH_DIV_STEP
    } arith_op_t;

    typedef struct packed {
        arith_op_t              op;
        logic [MUL_A_W-1:0]     mul_a;
        logic [MUL_B_W-1:0]     mul_b;
        logic [DIVIDEND_W-1:0]  dividend;
        logic [DIVISOR_W-1:0]   divisor;
    } arith_cmd_t;

    typedef struct packed {
        logic [PROD_W-1:0]      prod;
        logic [QUO_W-1:0]       quotient;
        logic                   div_done;
    } arith_rsp_t;

endpackage

### src/stepper_speed_to_step_pulse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_to_step_pulse
// Turns signed speed commands and microsecond ticks into step pulses, with
// clamping, a hysteresis deadband and reversal protection.
// ----------------------------------------------------------------------------
//  Channel  Signals                                    Direction
//  in       in_valid/in_ready, kind, speed_command     request in
//  out      out_valid/out_ready, step_pulse ...        result out
//  cfg      cfg_write, cfg_index, cfg_data             write only
//
//  Ticks, enable, disable, emergency stop and commands that end without a new
//  interval are handled in the accepting cycle. A command that sets a new
//  interval passes through the accepting cycle, three multiplies, a division
//  start, a 20-step restoring division on the shared arithmetic unit and the
//  quotient load. No clearing pass follows reset. A result waiting on out_ready
//  blocks the next request; the input is not ready while an interval is computed.
// ----------------------------------------------------------------------------
module stepper_speed_to_step_pulse
    import sspg_pkg::*;
#(
    parameter int SPEED_WIDTH    = 16,
    parameter int INTERVAL_WIDTH = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [KIND_W-1:0]             kind,
    input  logic signed [SPEED_WIDTH-1:0] speed_command,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          step_pulse,
    output logic                          direction,
    output logic [INTERVAL_WIDTH-1:0]     step_interval_us,
    output logic                          silenced,
    output logic                          enabled_flag,
    output logic signed [SPEED_WIDTH-1:0] applied_speed,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int EXT_W = ((SPEED_WIDTH > CTRL_W + 1) ? SPEED_WIDTH : CTRL_W + 1) + 1;
    localparam int SAT_W = (INTERVAL_WIDTH > QUO_W) ? INTERVAL_WIDTH : QUO_W;
    localparam logic [INTERVAL_WIDTH-1:0] IV_MAX = {INTERVAL_WIDTH{1'b1}};

    // Configuration
    logic [CTRL_W-1:0] max_control_reg, max_control_next;
    logic [FREQ_W-1:0] max_freq_reg,    max_freq_next;
    logic [CTRL_W-1:0] db_enter_reg,    db_enter_next;
    logic [CTRL_W-1:0] db_exit_reg,     db_exit_next;
    logic [FREQ_W-1:0] min_freq_reg,    min_freq_next;

    // Block state
    seq_state_t                    state_reg,    state_next;
    logic                          enabled_reg,  enabled_next;
    logic                          silent_reg,   silent_next;
    dir_t                          last_dir_reg, last_dir_next;
    logic [INTERVAL_WIDTH-1:0]     interval_reg, interval_next;
    logic [INTERVAL_WIDTH-1:0]     elapsed_reg,  elapsed_next;
    logic signed [SPEED_WIDTH-1:0] speed_reg,    speed_next;
    logic                          dir_pin_reg,  dir_pin_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          pulse_reg,    pulse_next;

    // Interval computation
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic [DIVISOR_W-1:0] num_reg, num_next;
    logic                 low_reg, low_next;

    // Command decode
    logic signed [EXT_W-1:0] s_ext;
    logic signed [EXT_W-1:0] mc_ext;
    logic signed [EXT_W-1:0] clamped;
    logic signed [EXT_W-1:0] neg_clamped;
    logic [MAG_W-1:0]        mag;
    logic                    want_fwd;
    dir_t                    want_dir;
    logic [CTRL_W-1:0]       mc1;
    logic [FREQ_W-1:0]       minf1;
    logic [INTERVAL_WIDTH-1:0] elapsed_inc;
    logic [SAT_W-1:0]        quo_ext;
    logic [INTERVAL_WIDTH-1:0] quo_sat;
    logic                    accept;

    arith_cmd_t cmd;
    arith_rsp_t rsp;

    sspg_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    assign s_ext       = EXT_W'(speed_command);
    assign mc_ext      = signed'(EXT_W'(max_control_reg));
    assign clamped     = (s_ext > mc_ext) ? mc_ext :
                         ((s_ext < -mc_ext) ? -mc_ext : s_ext);
    assign neg_clamped = -clamped;
    assign mag         = clamped[EXT_W-1] ? neg_clamped[MAG_W-1:0] : clamped[MAG_W-1:0];
    assign want_fwd    = !clamped[EXT_W-1];
    assign want_dir    = want_fwd ? DIR_FWD : DIR_REV;

    // A zero full scale or minimum frequency counts as one.
    assign mc1   = (max_control_reg == '0) ? CTRL_W'(1) : max_control_reg;
    assign minf1 = (min_freq_reg == '0) ? FREQ_W'(1) : min_freq_reg;

    assign elapsed_inc = (elapsed_reg < IV_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign quo_ext     = SAT_W'(rsp.quotient);
    assign quo_sat     = (quo_ext > SAT_W'(IV_MAX)) ? IV_MAX : INTERVAL_WIDTH'(quo_ext);

    assign in_ready = (state_reg == SEQ_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        max_control_next = max_control_reg;
        max_freq_next    = max_freq_reg;
        db_enter_next    = db_enter_reg;
        db_exit_next     = db_exit_reg;
        min_freq_next    = min_freq_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_CONTROL: max_control_next = cfg_data[CTRL_W-1:0];
                CFG_MAX_FREQ:    max_freq_next    = cfg_data[FREQ_W-1:0];
                CFG_DB_ENTER:    db_enter_next    = cfg_data[CTRL_W-1:0];
                CFG_DB_EXIT:     db_exit_next     = cfg_data[CTRL_W-1:0];
                CFG_MIN_FREQ:    min_freq_next    = cfg_data[FREQ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        enabled_next   = enabled_reg;
        silent_next    = silent_reg;
        last_dir_next  = last_dir_reg;
        interval_next  = interval_reg;
        elapsed_next   = elapsed_reg;
        speed_next     = speed_reg;
        dir_pin_next   = dir_pin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pulse_next     = pulse_reg;
        mag_next       = mag_reg;
        num_next       = num_reg;
        low_next       = low_reg;
        cmd.op         = ARITH_NOP;
        cmd.mul_a      = MUL_A_W'(mag_reg);
        cmd.mul_b      = max_freq_reg;
        cmd.dividend   = rsp.prod;
        cmd.divisor    = num_reg;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    pulse_next     = 1'b0;
                    case (kind_t'(kind))
                        KIND_SPEED:
                        begin
                            if (!enabled_reg)
                            begin
                                interval_next = '0;
                                silent_next   = 1'b1;
                            end
                            else
                            begin
                                speed_next = SPEED_WIDTH'(clamped);
                                if (silent_reg && (mag < db_exit_reg))
                                begin
                                    interval_next = '0;
                                end
                                else if (!silent_reg && (mag < db_enter_reg))
                                begin
                                    silent_next   = 1'b1;
                                    interval_next = '0;
                                    last_dir_next = DIR_NONE;
                                end
                                else if ((last_dir_reg == DIR_NONE) ||
                                         (last_dir_reg == want_dir))
                                begin
                                    // Running: the result waits for the new interval.
                                    silent_next    = 1'b0;
                                    dir_pin_next   = want_fwd;
                                    last_dir_next  = want_dir;
                                    mag_next       = mag;
                                    out_valid_next = 1'b0;
                                    state_next     = SEQ_MUL_NUM;
                                end
                                else
                                begin
                                    // Reversal while a direction is held.
                                    silent_next   = 1'b1;
                                    interval_next = '0;
                                    last_dir_next = DIR_NONE;
                                end
                            end
                        end
                        KIND_TICK:
                        begin
                            elapsed_next = elapsed_inc;
                            if (enabled_reg && (interval_reg != '0) &&
                                (elapsed_inc >= interval_reg))
                            begin
                                pulse_next   = 1'b1;
                                elapsed_next = '0;
                            end
                        end
                        KIND_ENABLE:
                        begin
                            enabled_next = 1'b1;
                        end
                        KIND_DISABLE:
                        begin
                            enabled_next  = 1'b0;
                            speed_next    = '0;
                            interval_next = '0;
                        end
                        KIND_ESTOP:
                        begin
                            speed_next    = '0;
                            interval_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            SEQ_MUL_NUM:
            begin
                cmd.op     = ARITH_MUL;
                state_next = SEQ_MUL_MIN;
            end
            SEQ_MUL_MIN:
            begin
                num_next   = rsp.prod[DIVISOR_W-1:0];
                cmd.op     = ARITH_MUL;
                cmd.mul_a  = MUL_A_W'(minf1);
                cmd.mul_b  = MUL_B_W'(mc1);
                state_next = SEQ_MUL_SCALE;
            end
            SEQ_MUL_SCALE:
            begin
                // Below the minimum frequency the interval comes from it alone.
                low_next   = num_reg < rsp.prod[DIVISOR_W-1:0];
                cmd.op     = ARITH_MUL;
                cmd.mul_a  = US_PER_S;
                cmd.mul_b  = MUL_B_W'(mc1);
                state_next = SEQ_DIV_START;
            end
            SEQ_DIV_START:
            begin
                cmd.op = ARITH_DIV_START;
                if (low_reg)
                begin
                    cmd.dividend = DIVIDEND_W'(US_PER_S);
                    cmd.divisor  = DIVISOR_W'(minf1);
                end
                state_next = SEQ_DIV;
            end
            SEQ_DIV:
            begin
                if (rsp.div_done)
                begin
                    interval_next  = quo_sat;
                    out_valid_next = 1'b1;
                    state_next     = SEQ_IDLE;
                end
                else
                begin
                    cmd.op = ARITH_DIV_STEP;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_control_reg <= RST_MAX_CONTROL;
            max_freq_reg    <= RST_MAX_FREQ;
            db_enter_reg    <= RST_DB_ENTER;
            db_exit_reg     <= RST_DB_EXIT;
            min_freq_reg    <= RST_MIN_FREQ;
            state_reg       <= SEQ_IDLE;
            enabled_reg     <= 1'b1;
            silent_reg      <= 1'b1;
            last_dir_reg    <= DIR_NONE;
            interval_reg    <= '0;
            elapsed_reg     <= '0;
            speed_reg       <= '0;
            dir_pin_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            pulse_reg       <= 1'b0;
        end
        else
        begin
            max_control_reg <= max_control_next;
            max_freq_reg    <= max_freq_next;
            db_enter_reg    <= db_enter_next;
            db_exit_reg     <= db_exit_next;
            min_freq_reg    <= min_freq_next;
            state_reg       <= state_next;
            enabled_reg     <= enabled_next;
            silent_reg      <= silent_next;
            last_dir_reg    <= last_dir_next;
            interval_reg    <= interval_next;
            elapsed_reg     <= elapsed_next;
            speed_reg       <= speed_next;
            dir_pin_reg     <= dir_pin_next;
            out_valid_reg   <= out_valid_next;
            pulse_reg       <= pulse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        num_reg <= num_next;
        low_reg <= low_next;
    end

    // The state behind the status fields only changes while no result is
    // pending, so the status fields come straight from the state.
    assign out_valid        = out_valid_reg;
    assign step_pulse       = pulse_reg;
    assign direction        = dir_pin_reg;
    assign step_interval_us = interval_reg;
    assign silenced         = silent_reg;
    assign enabled_flag     = enabled_reg;
    assign applied_speed    = speed_reg;

endmodule

### src/sspg_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspg_arith
// Shared arithmetic unit: one multiply, one division start or one restoring
// division step per command.
// ----------------------------------------------------------------------------
module sspg_arith
    import sspg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_cmd_t cmd,
    output arith_rsp_t rsp
);

    logic [PROD_W-1:0]          prod_reg,  prod_next;
    logic [DIVISOR_W-1:0]       rem_reg,   rem_next;
    logic [DIVISOR_W-1:0]       div_reg,   div_next;
    logic [QUO_W-1:0]           dvd_reg,   dvd_next;
    logic [QUO_W-1:0]           quo_reg,   quo_next;
    logic [CNT_W-1:0]           cnt_reg,   cnt_next;
    logic [MUL_A_W+MUL_B_W-1:0] prod_full;
    logic [DIVISOR_W:0]         trial;

    assign prod_full = cmd.mul_a * cmd.mul_b;
    assign trial     = {rem_reg, dvd_reg[QUO_W-1]};

    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        case (cmd.op)
            ARITH_MUL:
            begin
                prod_next = prod_full[PROD_W-1:0];
            end
            ARITH_DIV_START:
            begin
                // The quotient is known to fit QUO_W bits, so the bits of the
                // dividend above them already form a remainder below the divisor.
                rem_next = DIVISOR_W'(cmd.dividend[DIVIDEND_W-1:QUO_W]);
                dvd_next = cmd.dividend[QUO_W-1:0];
                div_next = cmd.divisor;
                quo_next = '0;
                cnt_next = '0;
            end
            ARITH_DIV_STEP:
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = DIVISOR_W'(trial - {1'b0, div_reg});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DIVISOR_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                dvd_next = {dvd_reg[QUO_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
    end

    assign rsp.prod     = prod_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.div_done = (cnt_reg == CNT_W'(QUO_W));

endmodule

### src/sspg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspg_checker
// Port-level checks for the stepper step-pulse generator, bound to the top.
// ----------------------------------------------------------------------------
module sspg_checker
    import sspg_pkg::*;
#(
    parameter int SPEED_WIDTH    = 16,
    parameter int INTERVAL_WIDTH = 20
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [KIND_W-1:0]             kind,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          step_pulse,
    input logic [INTERVAL_WIDTH-1:0]     step_interval_us,
    input logic                          enabled_flag,
    input logic signed [SPEED_WIDTH-1:0] applied_speed
);

    // A pulse is only possible while enabled with a running interval.
    a_pulse_needs_interval: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_pulse |-> enabled_flag && (step_interval_us != '0))
        else $error("step pulse without an enabled running interval");

    a_disable_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_DISABLE) |=>
            out_valid && !enabled_flag && (applied_speed == '0) &&
            (step_interval_us == '0))
        else $error("disable did not stop the motor");

    a_estop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_ESTOP) |=>
            out_valid && (applied_speed == '0) && (step_interval_us == '0))
        else $error("emergency stop did not clear speed and interval");

    // A pending result holds off the next request.
    a_pending_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while a result was pending");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_pulse) &&
            $stable(step_interval_us) && $stable(applied_speed))
        else $error("stalled result changed");

endmodule

bind stepper_speed_to_step_pulse sspg_checker #(
    .SPEED_WIDTH    (SPEED_WIDTH),
    .INTERVAL_WIDTH (INTERVAL_WIDTH)
) u_sspg_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper speed-to-step-pulse block. A scoreboard
// predicts every result from its own copy of the state and the registers, and
// results are compared field by field in order. Directed requests cover the
// deadband, reversal, disable and stop cases. Random requests then run under
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import sspg_pkg::*;

    localparam int SPEED_W     = 16;
    localparam int IV_W        = 20;
    localparam int IV_MAX      = (1 << IV_W) - 1;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct {
        logic                      pulse;
        logic                      dir;
        logic [IV_W-1:0]           interval;
        logic                      silenced;
        logic                      enabled;
        logic signed [SPEED_W-1:0] speed;
    } step_result_t;

    class step_scoreboard;
        logic [CTRL_W-1:0]         max_control;
        logic [FREQ_W-1:0]         max_freq;
        logic [CTRL_W-1:0]         db_enter;
        logic [CTRL_W-1:0]         db_exit;
        logic [FREQ_W-1:0]         min_freq;
        bit                        enabled;
        bit                        silent;
        dir_t                      held_dir;
        logic [IV_W-1:0]           interval;
        logic [IV_W-1:0]           elapsed;
        logic signed [SPEED_W-1:0] speed;
        bit                        dir_pin;
        step_result_t              pending[$];
        int                        errors;
        int                        requests;
        int                        checked;
        int                        pulses;
        int                        reversals;

        function new();
            max_control = RST_MAX_CONTROL;
            max_freq    = RST_MAX_FREQ;
            db_enter    = RST_DB_ENTER;
            db_exit     = RST_DB_EXIT;
            min_freq    = RST_MIN_FREQ;
            enabled     = 1'b1;
            silent      = 1'b1;
            held_dir    = DIR_NONE;
            interval    = '0;
            elapsed     = '0;
            speed       = '0;
            dir_pin     = 1'b0;
            errors      = 0;
            requests    = 0;
            checked     = 0;
            pulses      = 0;
            reversals   = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_MAX_CONTROL: max_control = v[CTRL_W-1:0];
                CFG_MAX_FREQ:    max_freq    = v[FREQ_W-1:0];
                CFG_DB_ENTER:    db_enter    = v[CTRL_W-1:0];
                CFG_DB_EXIT:     db_exit     = v[CTRL_W-1:0];
                CFG_MIN_FREQ:    min_freq    = v[FREQ_W-1:0];
                default: ;
            endcase
        endfunction

        function void apply_speed(logic signed [SPEED_W-1:0] cmd);
            longint s;
            longint lim;
            longint mag;
            longint scale;
            longint floor_hz;
            longint num;
            longint q;
            dir_t   want;
            if (!enabled) begin
                interval = '0;
                silent   = 1'b1;
                return;
            end
            lim = max_control;
            s   = cmd;
            if (s > lim)
                s = lim;
            if (s < -lim)
                s = -lim;
            speed = s[SPEED_W-1:0];
            mag   = (s < 0) ? -s : s;

            // Hysteresis: leaving silence needs the exit level, entering it
            // happens below the enter level.
            if (silent) begin
                if (mag < longint'(db_exit)) begin
                    interval = '0;
                    return;
                end
                silent = 1'b0;
            end
            else if (mag < longint'(db_enter)) begin
                silent   = 1'b1;
                interval = '0;
                held_dir = DIR_NONE;
                return;
            end

            want = (s >= 0) ? DIR_FWD : DIR_REV;
            if (held_dir == DIR_NONE || held_dir == want) begin
                dir_pin  = (want == DIR_FWD);
                held_dir = want;
            end
            else begin
                interval = '0;
                silent   = 1'b1;
                held_dir = DIR_NONE;
                reversals++;
                return;
            end

            scale    = (lim == 0) ? 1 : lim;
            floor_hz = (min_freq == 0) ? 1 : longint'(min_freq);
            num      = mag * longint'(max_freq);
            if (num < floor_hz * scale)
                q = 1000000 / floor_hz;
            else
                q = (64'd1000000 * scale) / num;
            interval = (q > IV_MAX) ? IV_MAX[IV_W-1:0] : q[IV_W-1:0];
        endfunction

        function void note_request(logic [KIND_W-1:0] k, logic signed [SPEED_W-1:0] cmd);
            step_result_t r;
            bit           pulse;
            pulse = 1'b0;
            requests++;
            case (k)
                KIND_SPEED: apply_speed(cmd);
                KIND_TICK: begin
                    if (elapsed < IV_MAX)
                        elapsed++;
                    if (enabled && interval != 0 && elapsed >= interval) begin
                        pulse   = 1'b1;
                        elapsed = '0;
                        pulses++;
                    end
                end
                KIND_ENABLE: enabled = 1'b1;
                KIND_DISABLE: begin
                    enabled  = 1'b0;
                    speed    = '0;
                    interval = '0;
                end
                KIND_ESTOP: begin
                    speed    = '0;
                    interval = '0;
                end
                default: ;
            endcase
            r.pulse    = pulse;
            r.dir      = dir_pin;
            r.interval = interval;
            r.silenced = silent;
            r.enabled  = enabled;
            r.speed    = speed;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result arrived with no request outstanding", $time);
                return;
            end
            want = pending.pop_front();
            checked++;
            compare_field("step_pulse", want.pulse, got.pulse);
            compare_field("direction", want.dir, got.dir);
            compare_field("step_interval_us", want.interval, got.interval);
            compare_field("silenced", want.silenced, got.silenced);
            compare_field("enabled_flag", want.enabled, got.enabled);
            compare_field("applied_speed", want.speed, got.speed);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [KIND_W-1:0]         kind;
    logic signed [SPEED_W-1:0] speed_command;
    logic                      out_valid;
    logic                      out_ready;
    logic                      step_pulse;
    logic                      direction;
    logic [IV_W-1:0]           step_interval_us;
    logic                      silenced;
    logic                      enabled_flag;
    logic signed [SPEED_W-1:0] applied_speed;
    logic                      cfg_write;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    step_scoreboard sb = new();
    int             cycle_count = 0;
    int             settings_used = 0;
    bit             quiet = 1'b0;

    stepper_speed_to_step_pulse #(
        .SPEED_WIDTH   (SPEED_W),
        .INTERVAL_WIDTH(IV_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .speed_command   (speed_command),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .step_pulse      (step_pulse),
        .direction       (direction),
        .step_interval_us(step_interval_us),
        .silenced        (silenced),
        .enabled_flag    (enabled_flag),
        .applied_speed   (applied_speed),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, sb.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Requests are noted before results in the same edge, so a result can
    // never be checked ahead of the request that caused it.
    always @(posedge clk)
    begin
        step_result_t got;
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_request(kind, speed_command);
            if (out_valid && out_ready) begin
                got.pulse    = step_pulse;
                got.dir      = direction;
                got.interval = step_interval_us;
                got.silenced = silenced;
                got.enabled  = enabled_flag;
                got.speed    = applied_speed;
                sb.check_result(got);
            end
        end
    end

    // Receiver stalls come in bursts, with calm windows where it never stalls.
    initial
    begin
        int stall;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && (cycle_count / 2000) % 3 != 2 && $urandom_range(0, 9) == 0) begin
                stall     = $urandom_range(1, 16);
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    task automatic send(logic [KIND_W-1:0] k, logic signed [SPEED_W-1:0] v);
        @(negedge clk);
        in_valid      = 1'b1;
        kind          = k;
        speed_command = v;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic idle(int n);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // Leave margin before the register writes.
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int v);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(v);
        @(negedge clk);
        cfg_write = 1'b0;
        sb.set_register(idx, CFG_DATA_W'(v));
    endtask

    task automatic load_settings(int mc, int mf, int enter_lvl, int exit_lvl, int mn);
        wait_drained();
        write_reg(CFG_MAX_CONTROL, mc);
        write_reg(CFG_MAX_FREQ, mf);
        write_reg(CFG_DB_ENTER, enter_lvl);
        write_reg(CFG_DB_EXIT, exit_lvl);
        write_reg(CFG_MIN_FREQ, mn);
        settings_used++;
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return KIND_TICK;
        else if (r < 88)
            return KIND_SPEED;
        else if (r < 92)
            return KIND_ENABLE;
        else if (r < 94)
            return KIND_DISABLE;
        else if (r < 96)
            return KIND_ESTOP;
        else
            return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    endfunction

    // Speeds cluster around the clamp and both deadband levels, with some
    // fully random words so that every bit toggles.
    function automatic logic signed [SPEED_W-1:0] pick_speed();
        int m;
        case ($urandom_range(0, 4))
            0: return SPEED_W'($urandom);
            1: m = $urandom_range(0, sb.max_control);
            2: m = int'(sb.db_exit) + int'($urandom_range(0, 2)) - 1;
            3: m = int'(sb.db_enter) + int'($urandom_range(0, 2)) - 1;
            default: m = int'(sb.max_control) + int'($urandom_range(0, 40));
        endcase
        if (m < 0)
            m = 0;
        if (m > 32767)
            m = 32767;
        if ($urandom_range(0, 1) == 1)
            m = -m;
        return SPEED_W'(m);
    endfunction

    task automatic run_random(int count, bit hold_midway);
        logic [KIND_W-1:0] k;
        for (int i = 0; i < count; i++)
        begin
            if (hold_midway && i == count / 2)
                wait_drained();
            if (!quiet && (cycle_count / 1500) % 3 != 1 && $urandom_range(0, 7) == 0)
                idle($urandom_range(1, 16));
            k = pick_kind();
            send(k, (k == KIND_SPEED) ? pick_speed() : SPEED_W'($urandom));
        end
    endtask

    initial
    begin
        int mc;
        int en;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_TICK;
        speed_command = '0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_MAX_CONTROL;
        cfg_data      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk through the deadband, reversal, stop and disable paths
        // under the reset settings.
        send(KIND_SPEED, 16'sd0);
        send(KIND_SPEED, 16'sh7fff);
        repeat (3) send(KIND_TICK, 16'sd0);
        send(KIND_SPEED, 16'sd100);
        send(KIND_SPEED, 16'sh8000);
        send(KIND_SPEED, 16'sh7fff);
        send(KIND_SPEED, 16'sd4000);
        send(KIND_SPEED, -16'sd1);
        send(KIND_SPEED, 16'sd399);
        send(KIND_SPEED, -16'sd400);
        send(KIND_SPEED, -16'sd127);
        send(KIND_SPEED, 16'sd600);
        send(KIND_TICK, 16'sd0);
        send(KIND_ESTOP, 16'sd0);
        send(KIND_TICK, 16'sh7fff);
        send(KIND_DISABLE, 16'sh7fff);
        send(KIND_SPEED, 16'sd2000);
        send(KIND_TICK, 16'sh8000);
        send(KIND_ENABLE, 16'sd0);
        send(KIND_SPEED, 16'sd128);
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            send(KIND_W'(k), -16'sd1);

        load_settings(100, 65535, 10, 20, 1000);
        run_random(300, 1'b1);
        load_settings(32767, 65535, 0, 0, 65535);
        run_random(200, 1'b0);
        load_settings(1, 1, 32767, 32767, 1);
        run_random(100, 1'b0);
        // Zero full-scale and zero floor frequency are treated as one.
        load_settings(0, 3000, 0, 0, 0);
        run_random(100, 1'b0);
        load_settings(200, 20000, 20, 60, 2000);
        run_random(250, 1'b0);
        mc = $urandom_range(50, 2000);
        en = $urandom_range(0, mc / 4);
        load_settings(mc, $urandom_range(20000, 65535), en,
                      $urandom_range(en, mc / 2), $urandom_range(1, 65535));
        run_random(150, 1'b0);
        quiet = 1'b1;
        load_settings(250, 65535, 5, 15, 1000);
        run_random(150, 1'b0);

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d requests of every kind under %0d register settings plus reset values.",
                 sb.requests, settings_used);
        $display("Checked %0d results: %0d step pulses, %0d direction reversals.",
                 sb.checked, sb.pulses, sb.reversals);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
